// ===== design/uxfat_pkg.sv =====
package uxfat_pkg;

	localparam int SecsW = 40;
	localparam int SpanW = 33;   // seconds below 2^33 cover every year up to 2107
	localparam int DaysW = 17;
	localparam int RemW  = 17;
	localparam int DoeW  = 18;
	localparam int EraW  = 3;
	localparam int YoeW  = 9;
	localparam int DoyW  = 9;
	localparam int MpW   = 4;
	localparam int YearW = 12;

	localparam logic [15:0] DefaultDate = 16'((1 << 5) | 1);
	localparam logic [YearW-1:0] YearLow  = YearW'(1980);
	localparam logic [YearW-1:0] YearHigh = YearW'(2107);

	typedef struct packed {
		logic              clock_valid;
		logic [SecsW-1:0]  unix_seconds;
	} req_item_t;

	typedef struct packed {
		logic [15:0] date_word;
		logic [15:0] time_word;
	} rsp_item_t;

	// first day of year-of-march month mp, i.e. (153*mp+2)/5
	function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
		logic [DoyW-1:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/uxfat_split.sv =====
module uxfat_split import uxfat_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SpanW-1:0] secs,
	output logic [RemW-1:0]  rem_s2,
	output logic [DoeW-1:0]  doe_s2,
	output logic [EraW-1:0]  era_s2
);

	localparam int QW = SpanW - 7;
	localparam int Shift = 36;
	localparam logic [26:0] RecipDay = 27'd101806633;  // ceil(2^36 / 675)
	localparam logic [19:0] EpochShift = 20'd719468;
	localparam int EraDays = 146097;

	logic [QW+26:0]     dprod;
	logic [DaysW-1:0]   days_s1;
	logic [RemW-1:0]    low_s1;
	logic [DaysW+16:0]  sprod;
	logic [19:0]        z;
	logic [EraW-1:0]    era;
	logic [19:0]        era_base;

	// seconds / 86400 = (seconds >> 7) / 675
	assign dprod = (QW+27)'(secs[SpanW-1:7]) * (QW+27)'(RecipDay);

	always_ff @(posedge clk) begin
		if (en) begin
			days_s1 <= dprod[Shift+DaysW-1:Shift];
			low_s1  <= secs[RemW-1:0];
		end
	end

	// remainder fits in 17 bits, so only the low bits of the product matter
	assign sprod = (DaysW+17)'(days_s1) * (DaysW+17)'(86400);
	assign z     = 20'(days_s1) + EpochShift;

	always_comb begin
		priority if (z >= 20'(5*EraDays)) begin
			era = 3'd5;
		end else if (z >= 20'(4*EraDays)) begin
			era = 3'd4;
		end else if (z >= 20'(3*EraDays)) begin
			era = 3'd3;
		end else if (z >= 20'(2*EraDays)) begin
			era = 3'd2;
		end else if (z >= 20'(EraDays)) begin
			era = 3'd1;
		end else begin
			era = 3'd0;
		end
		era_base = 20'(era) * 20'(EraDays);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= low_s1 - sprod[RemW-1:0];
			doe_s2 <= DoeW'(z - era_base);
			era_s2 <= era;
		end
	end

endmodule

// ===== design/uxfat_civil.sv =====
module uxfat_civil import uxfat_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DoeW-1:0]   doe_s2,
	input  logic [EraW-1:0]   era_s2,
	output logic [MpW-1:0]    mp_s6,
	output logic [DoyW-1:0]   doy_s6,
	output logic [YearW-1:0]  ybase_s6
);

	localparam logic [16:0] Recip1460 = 17'd91930;   // ceil(2^25 / 365), on doe >> 2
	localparam logic [18:0] Recip365  = 19'd367720;  // ceil(2^27 / 365)
	localparam logic [11:0] Recip153  = 12'd3427;    // ceil(2^19 / 153)

	// stage 3
	logic [32:0]      aprod;
	logic [7:0]       n1460;
	logic [2:0]       n36524;
	logic             n146096;
	logic [DoeW-1:0]  t;
	logic [DoeW-1:0]  t_s3;
	logic [DoeW-1:0]  doe_s3;
	logic [EraW-1:0]  era_s3;

	assign aprod   = 33'(doe_s2[DoeW-1:2]) * 33'(Recip1460);
	assign n1460   = aprod[32:25];
	assign n146096 = (doe_s2 == DoeW'(146096));

	always_comb begin
		n36524 = 3'd0;
		if (doe_s2 >= DoeW'(36524))  n36524 = 3'd1;
		if (doe_s2 >= DoeW'(73048))  n36524 = 3'd2;
		if (doe_s2 >= DoeW'(109572)) n36524 = 3'd3;
		if (doe_s2 >= DoeW'(146096)) n36524 = 3'd4;
		t = doe_s2 - DoeW'(n1460) + DoeW'(n36524) - DoeW'(n146096);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3   <= t;
			doe_s3 <= doe_s2;
			era_s3 <= era_s2;
		end
	end

	// stage 4: year of era
	logic [36:0]      yprod;
	logic [YoeW-1:0]  yoe_s4;
	logic [DoeW-1:0]  doe_s4;
	logic [EraW-1:0]  era_s4;

	assign yprod = 37'(t_s3) * 37'(Recip365);

	always_ff @(posedge clk) begin
		if (en) begin
			yoe_s4 <= yprod[27+YoeW-1:27];
			doe_s4 <= doe_s3;
			era_s4 <= era_s3;
		end
	end

	// stage 5: day of year and base year
	logic [1:0]        centuries;
	logic [DoeW-1:0]   ystart;
	logic [DoyW-1:0]   doy_s5;
	logic [YearW-1:0]  ybase_s5;

	always_comb begin
		centuries = 2'd0;
		if (yoe_s4 >= YoeW'(100)) centuries = 2'd1;
		if (yoe_s4 >= YoeW'(200)) centuries = 2'd2;
		if (yoe_s4 >= YoeW'(300)) centuries = 2'd3;
		ystart = DoeW'(yoe_s4) * DoeW'(365) + DoeW'(yoe_s4[YoeW-1:2]) - DoeW'(centuries);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s5   <= DoyW'(doe_s4 - ystart);
			ybase_s5 <= YearW'(yoe_s4) + YearW'(era_s4) * YearW'(400);
		end
	end

	// stage 6: month counted from march
	logic [10:0] mx;
	logic [22:0] mprod;

	assign mx    = 11'(doy_s5) * 11'd5 + 11'd2;
	assign mprod = 23'(mx) * 23'(Recip153);

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s6    <= mprod[22:19];
			doy_s6   <= doy_s5;
			ybase_s6 <= ybase_s5;
		end
	end

endmodule

// ===== design/uxfat_clock.sv =====
module uxfat_clock import uxfat_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [RemW-1:0]  rem_s2,
	output logic [15:0]      tw_s6
);

	localparam logic [15:0] Recip15 = 16'd34953;  // ceil(2^19 / 15), divide by 60 on x >> 2

	// stage 3: total minutes of the day
	logic [30:0]      mprod;
	logic [10:0]      mtot_s3;
	logic [RemW-1:0]  rem_s3;

	assign mprod = 31'(rem_s2[RemW-1:2]) * 31'(Recip15);

	always_ff @(posedge clk) begin
		if (en) begin
			mtot_s3 <= mprod[29:19];
			rem_s3  <= rem_s2;
		end
	end

	// stage 4: hour and seconds
	logic [24:0]      hprod;
	logic [RemW-1:0]  sec_full;
	logic [4:0]       hour_s4;
	logic [10:0]      mtot_s4;
	logic [5:0]       sec_s4;

	assign hprod    = 25'(mtot_s3[10:2]) * 25'(Recip15);
	assign sec_full = rem_s3 - RemW'(mtot_s3) * RemW'(60);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s4 <= hprod[23:19];
			mtot_s4 <= mtot_s3;
			sec_s4  <= sec_full[5:0];
		end
	end

	// stage 5: minute and packing
	logic [10:0]  min_full;
	logic [15:0]  tw_s5;

	assign min_full = mtot_s4 - 11'(hour_s4) * 11'd60;

	always_ff @(posedge clk) begin
		if (en) begin
			tw_s5 <= {hour_s4, min_full[5:0], sec_s4[5:1]};
			tw_s6 <= tw_s5;
		end
	end

endmodule

// ===== design/unix_seconds_to_fat_datetime_top.sv =====
// an accepted item passes the stage registers s1 to s6 and then the output register before its result is on rsp
// throughput: one item per cycle, the pipeline moves whenever the output register is free
// rsp_stall while rsp_valid is high backs up every stage at once and req_stall follows it in the same cycle
// reset clears the valid bits of all stages; data registers are not reset
module unix_seconds_to_fat_datetime_top import uxfat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_item_t  rsp
);

	logic              en;
	logic [6:1]        v_q;
	logic [6:1]        ok_q;
	logic [RemW-1:0]   rem_s2;
	logic [DoeW-1:0]   doe_s2;
	logic [EraW-1:0]   era_s2;
	logic [MpW-1:0]    mp_s6;
	logic [DoyW-1:0]   doy_s6;
	logic [YearW-1:0]  ybase_s6;
	logic [15:0]       tw_s6;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_q         <= {v_q[5:1], req_valid};
			rsp_valid_q <= v_q[6];
		end
	end

	// seconds at or above 2^33 lie past 2107 and give the default stamp
	always_ff @(posedge clk) begin
		if (en) begin
			ok_q <= {ok_q[5:1], req.clock_valid & ~|req.unix_seconds[SecsW-1:SpanW]};
		end
	end

	uxfat_split u_split (
		.clk    (clk),
		.en     (en),
		.secs   (req.unix_seconds[SpanW-1:0]),
		.rem_s2 (rem_s2),
		.doe_s2 (doe_s2),
		.era_s2 (era_s2)
	);

	uxfat_civil u_civil (
		.clk      (clk),
		.en       (en),
		.doe_s2   (doe_s2),
		.era_s2   (era_s2),
		.mp_s6    (mp_s6),
		.doy_s6   (doy_s6),
		.ybase_s6 (ybase_s6)
	);

	uxfat_clock u_clock (
		.clk    (clk),
		.en     (en),
		.rem_s2 (rem_s2),
		.tw_s6  (tw_s6)
	);

	// final stage: calendar month, day, year and range check
	logic [DoyW-1:0]   day_full;
	logic [MpW-1:0]    month;
	logic [YearW-1:0]  year;
	logic [YearW-1:0]  yoff;
	logic              in_range;
	rsp_item_t         rsp_d;

	always_comb begin
		day_full = doy_s6 - month_start(mp_s6) + DoyW'(1);
		month    = (mp_s6 < MpW'(10)) ? mp_s6 + MpW'(3) : mp_s6 - MpW'(9);
		year     = ybase_s6 + YearW'(month <= MpW'(2));
		yoff     = year - YearLow;
		in_range = ok_q[6] && (year >= YearLow) && (year <= YearHigh);
		if (in_range) begin
			rsp_d.date_word = {yoff[6:0], month, day_full[4:0]};
			rsp_d.time_word = tw_s6;
		end else begin
			rsp_d.date_word = DefaultDate;
			rsp_d.time_word = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== tb/sv/unix_seconds_to_fat_datetime_top_tb.sv =====
module unix_seconds_to_fat_datetime_top_tb import uxfat_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned   RandomItems = 2000;
	localparam int unsigned   CycleLimit  = 1_000_000;
	localparam int unsigned   LongHold    = 400;
	localparam int unsigned   SettleCycles = 20;
	localparam longint unsigned DaySecs   = 86400;
	localparam longint unsigned FatFirstDay = 3652;    // 1980-01-01
	localparam longint unsigned FatLastDay  = 50402;   // 2107-12-31
	localparam longint unsigned FatFirstSec = FatFirstDay * DaySecs;
	localparam longint unsigned FatEndSec   = (FatLastDay + 1) * DaySecs;

	class stamp_book;
		rsp_item_t   stamps_due[$];
		int unsigned mismatches = 0;
		int unsigned items_in = 0;
		int unsigned dated = 0;
		int unsigned defaulted = 0;

		// civil-from-days on a shifted epoch, then FAT packing
		function rsp_item_t fat_stamp(req_item_t r);
			longint unsigned secs, days, rem, z, era, doe, yoe, doy, mp, y, m, d;
			rsp_item_t o;
			o.date_word = DefaultDate;
			o.time_word = '0;
			if (r.clock_valid) begin
				secs = r.unix_seconds;
				days = secs / DaySecs;
				rem  = secs % DaySecs;
				z    = days + 719468;
				era  = z / 146097;
				doe  = z - era * 146097;
				yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
				doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
				mp   = (5 * doy + 2) / 153;
				y    = yoe + era * 400;
				d    = doy - (153 * mp + 2) / 5 + 1;
				m    = (mp < 10) ? mp + 3 : mp - 9;
				if (m <= 2)
					y = y + 1;
				if (y >= 1980 && y <= 2107) begin
					o.date_word = 16'(((y - 1980) << 9) | (m << 5) | d);
					o.time_word = 16'(((rem / 3600) << 11) | (((rem / 60) % 60) << 5)
						| ((rem % 60) / 2));
				end
			end
			return o;
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t o;
			o = fat_stamp(r);
			items_in++;
			if (o.date_word == DefaultDate && o.time_word == '0)
				defaulted++;
			else
				dated++;
			stamps_due.push_back(o);
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (stamps_due.size() == 0) begin
				$display("%0t: unexpected item date_word %h time_word %h", $time,
					got.date_word, got.time_word);
				mismatches++;
				return;
			end
			want = stamps_due.pop_front();
			if (got.date_word !== want.date_word) begin
				$display("%0t: date_word expected %h actual %h", $time, want.date_word,
					got.date_word);
				mismatches++;
			end
			if (got.time_word !== want.time_word) begin
				$display("%0t: time_word expected %h actual %h", $time, want.time_word,
					got.time_word);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return stamps_due.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	stamp_book   book = new();
	bit          hold_off = 1'b0;
	int unsigned long_holds = 0;
	int unsigned backed_up = 0;
	int unsigned cycles = 0;

	unix_seconds_to_fat_datetime_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d items still due", cycles, book.pending());
			$display("unix_seconds_to_fat_datetime_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_stall)
				backed_up++;
			if (req_valid && !req_stall)
				book.note_request(req);
			if (rsp_valid && !rsp_stall)
				book.check_response(rsp);
		end
	end

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_item_t make_item(bit cv, longint unsigned secs);
		req_item_t it;
		it.clock_valid  = cv;
		it.unix_seconds = secs[SecsW-1:0];
		return it;
	endfunction

	function automatic req_item_t random_item();
		int unsigned     pick;
		bit              cv;
		longint unsigned secs;
		longint unsigned base;
		pick = $urandom_range(0, 99);
		cv   = ($urandom_range(0, 9) != 0);
		if (pick < 65) begin
			secs = longint'($urandom_range(32'(FatFirstDay - 3), 32'(FatLastDay + 3)))
				* DaySecs + $urandom_range(0, 86399);
		end else if (pick < 80) begin
			// around the first and last second of the FAT range
			base = $urandom_range(0, 1) ? FatFirstSec : FatEndSec;
			secs = base + $urandom_range(0, 400) - 200;
		end else if (pick < 90) begin
			secs = {$urandom(), $urandom()};
		end else begin
			secs = {31'd0, 1'($urandom_range(0, 1)), 32'($urandom())};
		end
		return make_item(cv, secs);
	endfunction

	task automatic send_item(input req_item_t it);
		req       <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic idle(input int unsigned n);
		if (n != 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (book.pending() != 0);
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		bit          stall_now;
		int unsigned span;
		int unsigned p;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				stall_now = 1'b1;
				span      = LongHold;
				hold_off  = 1'b0;
				long_holds++;
			end else begin
				p         = $urandom_range(0, 99);
				stall_now = (p < 35);
				if (stall_now)
					span = gap_len() + 1;
				else
					span = (p < 80) ? $urandom_range(1, 4) : $urandom_range(20, 80);
			end
			rsp_stall <= stall_now;
			repeat (span) @(posedge clk);
		end
	end

	initial begin : sender
		req_item_t   directed[$];
		int unsigned i;
		bit          burst;
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_item(1'b0, 64'd0));
		directed.push_back(make_item(1'b1, 64'd0));                      // 1970, before range
		directed.push_back(make_item(1'b1, 64'hFF_FFFF_FFFF));           // far future
		directed.push_back(make_item(1'b0, 64'hFF_FFFF_FFFF));
		directed.push_back(make_item(1'b0, FatFirstSec + 12345));        // valid date, clock off
		directed.push_back(make_item(1'b1, FatFirstSec - 1));
		directed.push_back(make_item(1'b1, FatFirstSec));
		directed.push_back(make_item(1'b1, FatFirstSec + 1));            // odd second truncated
		directed.push_back(make_item(1'b1, FatEndSec - 1));              // 2107-12-31 23:59:59
		directed.push_back(make_item(1'b1, FatEndSec));
		directed.push_back(make_item(1'b1, 11016 * DaySecs));            // 2000-02-29
		directed.push_back(make_item(1'b1, 11016 * DaySecs - 1));
		directed.push_back(make_item(1'b1, 47540 * DaySecs + 86399));    // 2100-02-28, no leap day
		directed.push_back(make_item(1'b1, 47541 * DaySecs));            // 2100-03-01
		directed.push_back(make_item(1'b1, 64'h0_FFFF_FFFF));
		directed.push_back(make_item(1'b1, 64'h1_0000_0000));
		directed.push_back(make_item(1'b1, 64'h1_FFFF_FFFF));
		directed.push_back(make_item(1'b1, 64'h2_0000_0000));
		directed.push_back(make_item(1'b1, 64'h55_5555_5555));
		directed.push_back(make_item(1'b1, 64'hAA_AAAA_AAAA));
		directed.push_back(make_item(1'b1, 64'h80_0000_0000));
		directed.push_back(make_item(1'b1, 20000 * DaySecs + 43199));
		foreach (directed[k]) begin
			send_item(directed[k]);
			idle(gap_len());
		end
		drain();

		for (i = 0; i < RandomItems; i++) begin
			if (i == 400)
				hold_off = 1'b1;
			if (i == 1200)
				drain();
			burst = ((i / 150) % 4 == 1);
			send_item(random_item());
			if (!burst)
				idle(gap_len());
		end

		drain();
		repeat (SettleCycles) @(posedge clk);

		$display("%0d items checked: %0d with a FAT stamp, %0d with the default stamp",
			book.items_in, book.dated, book.defaulted);
		$display("%0d long output hold-offs, %0d cycles with the input backed up",
			long_holds, backed_up);
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("unix_seconds_to_fat_datetime_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d items never arrived", book.mismatches,
				book.pending());
			$display("unix_seconds_to_fat_datetime_top regression: fail");
		end
		$finish;
	end

endmodule
